// File: design/tscd_pkg.sv
// Shared types and constants for the two-stage clock divider search.
// Used by tscd_div and two_stage_clock_divider_search; no dependencies.
package tscd_pkg;

  // Divider datapath widths: widest dividend is the request in Hz
  localparam int unsigned DvdW = 28;
  localparam int unsigned DvsW = 20;
  localparam int unsigned CntW = $clog2(DvdW);

  // Field widths
  localparam int unsigned HzW   = 28;
  localparam int unsigned KhzW  = 20;
  localparam int unsigned ReqW  = 18;
  localparam int unsigned DivW  = 8;
  localparam int unsigned RateW = 20;

  typedef logic [DvdW-1:0] dvd_t;
  typedef logic [DvsW-1:0] dvs_t;
  typedef logic [KhzW-1:0] khz_t;
  typedef logic [ReqW-1:0] req_t;
  typedef logic [DivW-1:0] div_t;
  typedef logic [RateW-1:0] rate_t;
  typedef logic [HzW-1:0] hz_t;

  // Saturation limits
  localparam hz_t  ReqMinHz    = 28'd1000;
  localparam hz_t  ReqMaxHz    = 28'd148000000;
  localparam khz_t SrcMinKhz   = 20'd1;
  localparam khz_t SrcMaxKhz   = 20'd1000000;
  localparam khz_t SrcResetKhz = 20'd297931;

  // Divisor and search constants
  localparam dvs_t HzPerKhz     = 20'd1000;
  // Prescale 2k qualifies when ratio < 257 * 2k, so k = ratio / 514 + 1
  localparam dvs_t PrescaleStep = 20'd514;
  localparam dvd_t PrescaleKMax = 28'd125;
  localparam div_t DivFallback  = 8'd254;
  localparam div_t DivLast      = 8'd252;
  localparam rate_t RateLimit   = 20'd256;
  localparam div_t RateM1Max    = 8'd255;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KHZ,
    ST_RATIO,
    ST_PRESCALE,
    ST_RATE,
    ST_QUOT,
    ST_NEED,
    ST_ACH,
    ST_DONE
  } state_e;

endpackage

// File: design/tscd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tscd_pkg for widths and types.
module tscd_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tscd_pkg::dvd_t dividend_i,
  input  tscd_pkg::dvs_t divisor_i,
  output tscd_pkg::dvd_t quotient_o,
  output logic           done_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [tscd_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [tscd_pkg::DvsW:0]         rem_q, rem_d;
  tscd_pkg::dvd_t                  quo_q, quo_d;
  tscd_pkg::dvs_t                  dvs_q, dvs_d;
  logic [tscd_pkg::DvsW:0]         shifted;
  logic                            fits;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    shifted = {rem_q[tscd_pkg::DvsW-1:0], quo_q[tscd_pkg::DvdW-1]};
    fits    = shifted >= {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tscd_pkg::CntW'(tscd_pkg::DvdW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_d = {quo_q[tscd_pkg::DvdW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

  // A new division is never launched over a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");
  // The last step always reports completion next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && cnt_q == '0 |=> done_q && !busy_q)
    else $error("divider missed completion");
  // Completion only follows a running division
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("divider done without work");

endmodule

// File: design/two_stage_clock_divider_search.sv
// Two-stage clock divider search: request in Hz to prescale divide and rate.
// Each request runs seven serial divisions on the shared one-bit-per-cycle
// divider. The input stalls until the previous result is loaded into the
// output register, and the next input is taken while a result still waits
// at the output register. Reset clears control state and loads the source
// clock register with 297931 kHz; no clearing pass.
module two_stage_clock_divider_search (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  tscd_pkg::khz_t        cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tscd_pkg::hz_t         requested_hz_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tscd_pkg::div_t        prescale_divide_o,
  output tscd_pkg::div_t        rate_minus_one_o,
  output tscd_pkg::khz_t        achieved_khz_o,
  output logic                  rate_clamped_o
);

  tscd_pkg::state_e state_q, state_d;
  logic             launch_q, launch_d;
  logic             out_valid_q, out_valid_d;
  tscd_pkg::khz_t   src_cfg_q;
  tscd_pkg::khz_t   src_eff;

  tscd_pkg::hz_t    hz_q, hz_d;
  tscd_pkg::req_t   req_q, req_d;
  tscd_pkg::khz_t   ratio_q, ratio_d;
  tscd_pkg::div_t   div_q, div_d;
  logic             fallback_q, fallback_d;
  tscd_pkg::rate_t  rate_q, rate_d;
  tscd_pkg::khz_t   qv_q, qv_d;
  tscd_pkg::khz_t   ach_q, ach_d;

  tscd_pkg::div_t   pd_out_q;
  tscd_pkg::div_t   rm1_out_q;
  tscd_pkg::khz_t   ach_out_q;
  logic             clamp_out_q;
  logic             load_out;

  tscd_pkg::dvd_t   dvd;
  tscd_pkg::dvs_t   dvs;
  tscd_pkg::dvd_t   quo;
  logic             div_done;
  tscd_pkg::rate_t  need;
  logic             rate_over;

  // Source clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cfg_q <= tscd_pkg::SrcResetKhz;
    end else if (cfg_we_i) begin
      src_cfg_q <= cfg_wdata_i;
    end
  end

  // Saturate the source clock
  always_comb begin
    if (src_cfg_q < tscd_pkg::SrcMinKhz) begin
      src_eff = tscd_pkg::SrcMinKhz;
    end else if (src_cfg_q > tscd_pkg::SrcMaxKhz) begin
      src_eff = tscd_pkg::SrcMaxKhz;
    end else begin
      src_eff = src_cfg_q;
    end
  end

  // Select the operands of the current division
  always_comb begin
    unique case (state_q)
      tscd_pkg::ST_KHZ: begin
        dvd = hz_q;
        dvs = tscd_pkg::HzPerKhz;
      end
      tscd_pkg::ST_RATIO: begin
        dvd = tscd_pkg::dvd_t'(src_eff);
        dvs = tscd_pkg::dvs_t'(req_q);
      end
      tscd_pkg::ST_PRESCALE: begin
        dvd = tscd_pkg::dvd_t'(ratio_q);
        dvs = tscd_pkg::PrescaleStep;
      end
      tscd_pkg::ST_RATE: begin
        dvd = tscd_pkg::dvd_t'(ratio_q);
        dvs = tscd_pkg::dvs_t'(fallback_q ? tscd_pkg::DivLast : div_q);
      end
      tscd_pkg::ST_QUOT: begin
        dvd = tscd_pkg::dvd_t'(src_eff);
        dvs = tscd_pkg::dvs_t'(div_q);
      end
      tscd_pkg::ST_NEED: begin
        dvd = tscd_pkg::dvd_t'(qv_q);
        dvs = tscd_pkg::dvs_t'(req_q) + 1'b1;
      end
      tscd_pkg::ST_ACH: begin
        dvd = tscd_pkg::dvd_t'(qv_q);
        dvs = tscd_pkg::dvs_t'(rate_q);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  tscd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (launch_q),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign need      = tscd_pkg::rate_t'(quo) + 1'b1;
  assign rate_over = rate_q > tscd_pkg::RateLimit;

  // Sequence the divisions and collect their results
  always_comb begin
    state_d    = state_q;
    launch_d   = 1'b0;
    load_out   = 1'b0;
    hz_d       = hz_q;
    req_d      = req_q;
    ratio_d    = ratio_q;
    div_d      = div_q;
    fallback_d = fallback_q;
    rate_d     = rate_q;
    qv_d       = qv_q;
    ach_d      = ach_q;
    unique case (state_q)
      tscd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (requested_hz_i < tscd_pkg::ReqMinHz) begin
            hz_d = tscd_pkg::ReqMinHz;
          end else if (requested_hz_i > tscd_pkg::ReqMaxHz) begin
            hz_d = tscd_pkg::ReqMaxHz;
          end else begin
            hz_d = requested_hz_i;
          end
          state_d  = tscd_pkg::ST_KHZ;
          launch_d = 1'b1;
        end
      end
      tscd_pkg::ST_KHZ: begin
        if (div_done) begin
          req_d    = tscd_pkg::req_t'(quo);
          state_d  = tscd_pkg::ST_RATIO;
          launch_d = 1'b1;
        end
      end
      tscd_pkg::ST_RATIO: begin
        if (div_done) begin
          ratio_d  = tscd_pkg::khz_t'(quo);
          state_d  = tscd_pkg::ST_PRESCALE;
          launch_d = 1'b1;
        end
      end
      tscd_pkg::ST_PRESCALE: begin
        if (div_done) begin
          // Fall back to the top divide when no even divide qualifies
          if (quo > tscd_pkg::PrescaleKMax) begin
            fallback_d = 1'b1;
            div_d      = tscd_pkg::DivFallback;
          end else begin
            fallback_d = 1'b0;
            div_d      = {7'(quo[6:0] + 7'd1), 1'b0};
          end
          state_d  = tscd_pkg::ST_RATE;
          launch_d = 1'b1;
        end
      end
      tscd_pkg::ST_RATE: begin
        if (div_done) begin
          // Repair a zero first rate
          rate_d   = (quo == '0) ? tscd_pkg::rate_t'(1) : tscd_pkg::rate_t'(quo);
          state_d  = tscd_pkg::ST_QUOT;
          launch_d = 1'b1;
        end
      end
      tscd_pkg::ST_QUOT: begin
        if (div_done) begin
          qv_d     = tscd_pkg::khz_t'(quo);
          state_d  = tscd_pkg::ST_NEED;
          launch_d = 1'b1;
        end
      end
      tscd_pkg::ST_NEED: begin
        if (div_done) begin
          // Raise the rate until the achieved clock stays within the request
          if (rate_q < need) begin
            rate_d = need;
          end
          state_d  = tscd_pkg::ST_ACH;
          launch_d = 1'b1;
        end
      end
      tscd_pkg::ST_ACH: begin
        if (div_done) begin
          ach_d   = tscd_pkg::khz_t'(quo);
          state_d = tscd_pkg::ST_DONE;
        end
      end
      tscd_pkg::ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = tscd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tscd_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: drop on a taken transaction, set on a new load
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tscd_pkg::ST_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    hz_q       <= hz_d;
    req_q      <= req_d;
    ratio_q    <= ratio_d;
    div_q      <= div_d;
    fallback_q <= fallback_d;
    rate_q     <= rate_d;
    qv_q       <= qv_d;
    ach_q      <= ach_d;
  end

  // Output register, with the rate clamp applied on load
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pd_out_q    <= div_q;
      rm1_out_q   <= rate_over ? tscd_pkg::RateM1Max
                               : tscd_pkg::div_t'(rate_q - 1'b1);
      ach_out_q   <= ach_q;
      clamp_out_q <= rate_over;
    end
  end

  assign in_stall_o        = state_q != tscd_pkg::ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign prescale_divide_o = pd_out_q;
  assign rate_minus_one_o  = rm1_out_q;
  assign achieved_khz_o    = ach_out_q;
  assign rate_clamped_o    = clamp_out_q;

  // Divider completion arrives only while a division step is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q != tscd_pkg::ST_IDLE && state_q != tscd_pkg::ST_DONE)
    else $error("division result with no division pending");
  // The sequencer waits in place while the divider runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |=> state_q == $past(state_q))
    else $error("sequencer moved during a division");
  // A clamped rate always reports the top rate code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && clamp_out_q |-> rm1_out_q == tscd_pkg::RateM1Max)
    else $error("clamped rate with wrong code");
  // The prescale divide is always even and nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !pd_out_q[0] && pd_out_q != '0)
    else $error("bad prescale divide");

endmodule

// File: bench/two_stage_clock_divider_search_tb.sv
// Self-checking testbench for the two-stage clock divider search block.
// Depends on tscd_pkg and two_stage_clock_divider_search; drives requests and
// source clock writes, predicts each divider setting and checks every result.
`timescale 1ns / 1ps

module two_stage_clock_divider_search_tb;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned IdlePercent = 31;
  localparam int unsigned HoldOffLen  = 1500;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned PhaseItems  = 50;

  // One result transaction of the block
  typedef struct packed {
    tscd_pkg::div_t prescale_divide;
    tscd_pkg::div_t rate_minus_one;
    tscd_pkg::khz_t achieved_khz;
    logic           rate_clamped;
  } divider_setting_t;

  logic           clk_i          = 1'b0;
  logic           rst_ni         = 1'b0;
  logic           cfg_we_i       = 1'b0;
  tscd_pkg::khz_t cfg_wdata_i    = '0;
  logic           in_valid_i     = 1'b0;
  logic           in_stall_o;
  tscd_pkg::hz_t  requested_hz_i = '0;
  logic           out_valid_o;
  logic           out_stall_i    = 1'b0;
  tscd_pkg::div_t prescale_divide_o;
  tscd_pkg::div_t rate_minus_one_o;
  tscd_pkg::khz_t achieved_khz_o;
  logic           rate_clamped_o;

  divider_setting_t expected_settings[$];
  tscd_pkg::khz_t source_model     = tscd_pkg::SrcResetKhz;
  bit          sender_idles      = 1'b1;
  bit          receiver_idles    = 1'b1;
  int unsigned hold_off_request  = 0;
  int unsigned hold_left         = 0;
  int unsigned cycle_count       = 0;
  int unsigned error_count       = 0;
  int unsigned request_count     = 0;
  int unsigned setting_count     = 0;
  int unsigned source_count      = 1;
  int unsigned clamp_count       = 0;
  int unsigned fallback_count    = 0;
  int unsigned zero_rate_count   = 0;

  two_stage_clock_divider_search i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .requested_hz_i   (requested_hz_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .prescale_divide_o(prescale_divide_o),
    .rate_minus_one_o (rate_minus_one_o),
    .achieved_khz_o   (achieved_khz_o),
    .rate_clamped_o   (rate_clamped_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Work out the divide, rate and achieved kHz for one request
  function automatic divider_setting_t predict_divider_setting(tscd_pkg::khz_t src_reg,
                                                               tscd_pkg::hz_t hz);
    int unsigned src, req, divide, rate, quot, need, achieved;
    bit found;
    divider_setting_t res;
    src = src_reg;
    if (src < tscd_pkg::SrcMinKhz) src = tscd_pkg::SrcMinKhz;
    if (src > tscd_pkg::SrcMaxKhz) src = tscd_pkg::SrcMaxKhz;
    req = hz;
    if (req < tscd_pkg::ReqMinHz) req = tscd_pkg::ReqMinHz;
    if (req > tscd_pkg::ReqMaxHz) req = tscd_pkg::ReqMaxHz;
    req = req / tscd_pkg::HzPerKhz;
    // first even divide that brings the rate down to the limit
    rate = 0;
    divide = 2;
    found = 1'b0;
    while (!found && divide < tscd_pkg::DivFallback) begin
      rate = src / req / divide;
      if (rate <= tscd_pkg::RateLimit) found = 1'b1;
      else divide = divide + 2;
    end
    if (rate == 0) rate = 1;
    // raise the rate until the output no longer exceeds the request
    quot = src / divide;
    need = quot / (req + 1) + 1;
    if (rate < need) rate = need;
    achieved = quot / rate;
    res.rate_clamped = (rate > tscd_pkg::RateLimit);
    if (rate > tscd_pkg::RateLimit) rate = tscd_pkg::RateLimit;
    res.prescale_divide = tscd_pkg::div_t'(divide);
    res.rate_minus_one  = tscd_pkg::div_t'(rate - 1);
    res.achieved_khz    = tscd_pkg::khz_t'(achieved);
    return res;
  endfunction

  // Request generator: mostly log-spread rates, some raw and edge values
  function automatic tscd_pkg::hz_t random_request();
    int unsigned shift, khz;
    tscd_pkg::hz_t hz;
    case ($urandom_range(0, 9))
      0: hz = tscd_pkg::hz_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: hz = tscd_pkg::hz_t'($urandom_range(0, 1999));
          1: hz = tscd_pkg::hz_t'($urandom_range(147999000, 148001000));
          2: hz = tscd_pkg::hz_t'(28'hFFFFFFF - $urandom_range(0, 1000));
          default: hz = tscd_pkg::hz_t'($urandom_range(0, 3) * 1000 + $urandom_range(0, 999));
        endcase
      end
      default: begin
        shift = $urandom_range(0, 17);
        khz = (1 << shift) | ($urandom & ((1 << shift) - 1));
        hz = tscd_pkg::hz_t'(khz * 1000 + $urandom_range(0, 999));
      end
    endcase
    return hz;
  endfunction

  function automatic tscd_pkg::khz_t random_source();
    int unsigned shift;
    tscd_pkg::khz_t src;
    case ($urandom_range(0, 7))
      0: src = tscd_pkg::SrcMinKhz;
      1: src = tscd_pkg::SrcMaxKhz;
      2: src = tscd_pkg::khz_t'($urandom);
      3: src = tscd_pkg::khz_t'($urandom_range(0, 1));
      default: begin
        shift = $urandom_range(0, 19);
        src = tscd_pkg::khz_t'((1 << shift) | ($urandom & ((1 << shift) - 1)));
      end
    endcase
    return src;
  endfunction

  // Offer one request, hold it until accepted, and queue its expected setting
  task automatic send_request(input tscd_pkg::hz_t hz);
    divider_setting_t setting;
    while (sender_idles && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    requested_hz_i <= hz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    setting = predict_divider_setting(source_model, hz);
    expected_settings.push_back(setting);
    request_count++;
    if (setting.rate_clamped) clamp_count++;
    if (setting.prescale_divide == tscd_pkg::DivFallback) fallback_count++;
    if (setting.achieved_khz == '0) zero_rate_count++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_settings.size() != 0) @(negedge clk_i);
  endtask

  // Write the source clock register; caller makes sure the block is idle
  task automatic write_source_clock(input tscd_pkg::khz_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    source_model = value;
    source_count++;
  endtask

  task automatic test_reset_source();
    send_request(tscd_pkg::hz_t'(1000));
    send_request(tscd_pkg::hz_t'(148000000));
    send_request(tscd_pkg::hz_t'(0));
    send_request(tscd_pkg::hz_t'(999));
    send_request(tscd_pkg::hz_t'(148000001));
    send_request(tscd_pkg::hz_t'(28'hFFFFFFF));
    send_request(tscd_pkg::hz_t'(1999));
    send_request(tscd_pkg::hz_t'(400000));
    send_request(tscd_pkg::hz_t'(25000000));
    wait_drained();
  endtask

  // Source at its floor: the first rate comes out zero and is repaired
  task automatic test_zero_first_rate();
    write_source_clock(tscd_pkg::SrcMinKhz);
    send_request(tscd_pkg::hz_t'(148000000));
    send_request(tscd_pkg::hz_t'(1000));
    wait_drained();
    write_source_clock('0);
    send_request(tscd_pkg::hz_t'(50000000));
    send_request(tscd_pkg::hz_t'(2000));
    wait_drained();
  endtask

  // Fast source: for slow requests no divide qualifies and the rate clamps
  task automatic test_fallback_clamp();
    write_source_clock(tscd_pkg::SrcMaxKhz);
    send_request(tscd_pkg::hz_t'(1000));
    send_request(tscd_pkg::hz_t'(2000));
    send_request(tscd_pkg::hz_t'(3999));
    wait_drained();
    write_source_clock(tscd_pkg::khz_t'(20'hFFFFF));
    send_request(tscd_pkg::hz_t'(1000));
    send_request(tscd_pkg::hz_t'(148000000));
    send_request(tscd_pkg::hz_t'(7000));
    wait_drained();
  endtask

  // Random requests over a series of source clock settings
  task automatic test_random_sources();
    int unsigned phase;
    for (phase = 0; phase < RandomItems / PhaseItems; phase++) begin
      write_source_clock(random_source());
      sender_idles   = (phase != 3);
      receiver_idles = (phase != 3);
      repeat (PhaseItems) send_request(random_request());
      wait_drained();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Hold off the receiver long enough that the block stalls its input
  task automatic test_output_backpressure();
    write_source_clock(tscd_pkg::SrcResetKhz);
    hold_off_request = HoldOffLen;
    repeat (8) send_request(random_request());
    wait_drained();
  endtask

  // Receiver side: long hold-off on request, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_off_request != 0) begin
      hold_left        = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (receiver_idles) begin
      out_stall_i <= ($urandom_range(0, 99) < IdlePercent);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expected setting
  always @(posedge clk_i) begin
    divider_setting_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_settings.size() == 0) begin
        $error("unexpected result: divide %0d rate_m1 %0d achieved %0d clamped %0d",
               prescale_divide_o, rate_minus_one_o, achieved_khz_o, rate_clamped_o);
        error_count++;
      end else begin
        want = expected_settings.pop_front();
        setting_count++;
        if (prescale_divide_o !== want.prescale_divide) begin
          $error("prescale_divide mismatch: expected %0d, actual %0d",
                 want.prescale_divide, prescale_divide_o);
          error_count++;
        end
        if (rate_minus_one_o !== want.rate_minus_one) begin
          $error("rate_minus_one mismatch: expected %0d, actual %0d",
                 want.rate_minus_one, rate_minus_one_o);
          error_count++;
        end
        if (achieved_khz_o !== want.achieved_khz) begin
          $error("achieved_khz mismatch: expected %0d, actual %0d",
                 want.achieved_khz, achieved_khz_o);
          error_count++;
        end
        if (rate_clamped_o !== want.rate_clamped) begin
          $error("rate_clamped mismatch: expected %0d, actual %0d",
                 want.rate_clamped, rate_clamped_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("two_stage_clock_divider_search verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_source();
    test_zero_first_rate();
    test_fallback_clamp();
    test_random_sources();
    test_output_backpressure();
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    $display("Checked %0d results from %0d requests over %0d source clock settings",
             setting_count, request_count, source_count);
    $display("Saw %0d clamped rates, %0d fallback divides, %0d zero kHz outputs",
             clamp_count, fallback_count, zero_rate_count);
    if (error_count == 0) begin
      $display("two_stage_clock_divider_search verification clean");
    end else begin
      $display("two_stage_clock_divider_search verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/tscd_pkg.sv
design/tscd_div.sv
design/two_stage_clock_divider_search.sv
bench/two_stage_clock_divider_search_tb.sv
